FILE: rtl/mps_pkg.sv
// mps_pkg: shared types, codes and constants of the maneuver plan sequencer
// used by mps_csr_regs, mps_step_eval and maneuver_plan_sequencer_core
package mps_pkg;

   localparam int unsigned MaxSteps      = 7;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 39;
   localparam int unsigned PlanLenWidth  = 3;

   // 1000 m in Q16.16, and a quarter turn in Q2.14 radians
   localparam logic signed [32:0] OffsetQ16   = 33'sd65536000;
   localparam logic signed [15:0] YawQuarter  = 16'sd25736;
   localparam logic signed [32:0] Int32Max    = 33'sd2147483647;
   localparam logic signed [32:0] Int32Min    = -33'sd2147483648;

   // configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PLAN_LENGTH = 3'd0,
      CSR_STEP_WORD_0 = 3'd1,
      CSR_STEP_WORD_1 = 3'd2,
      CSR_STEP_WORD_2 = 3'd3,
      CSR_STEP_WORD_3 = 3'd4,
      CSR_STEP_WORD_4 = 3'd5,
      CSR_STEP_WORD_5 = 3'd6,
      CSR_STEP_WORD_6 = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      MAN_PARK          = 3'd0,
      MAN_REVERSE       = 3'd1,
      MAN_REVERSE_LEFT  = 3'd2,
      MAN_REVERSE_RIGHT = 3'd3,
      MAN_DRIVE         = 3'd4,
      MAN_DRIVE_LEFT    = 3'd5,
      MAN_DRIVE_RIGHT   = 3'd6,
      MAN_UNKNOWN       = 3'd7
   } maneuver_type;

   typedef enum logic [3:0] {
      TR_DURATION     = 4'd0,
      TR_X_ABOVE      = 4'd1,
      TR_X_BELOW      = 4'd2,
      TR_LEFT_ABOVE   = 4'd3,
      TR_LEFT_BELOW   = 4'd4,
      TR_MIDDLE_ABOVE = 4'd5,
      TR_MIDDLE_BELOW = 4'd6,
      TR_RIGHT_ABOVE  = 4'd7,
      TR_RIGHT_BELOW  = 4'd8
   } step_exit_type;

   typedef enum logic [1:0] {
      ST_RUNNING   = 2'd0,
      ST_IDLE      = 2'd1,
      ST_COMPLETED = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // one step word: threshold in bits 38:7, transition 6:3, maneuver 2:0
   typedef struct packed {
      logic signed [31:0] threshold;
      step_exit_type      transition;
      maneuver_type       maneuver;
   } step_word_type;

   typedef step_word_type [MaxSteps-1:0] step_table_type;

   // one control tick
   typedef struct packed {
      logic               start_request;
      logic               controller_active;
      logic        [31:0] time_ms;
      logic signed [31:0] pos_x;
      logic signed [31:0] tof_left;
      logic signed [31:0] tof_mid;
      logic signed [31:0] tof_right;
   } tick_type;

   // sequencer state carried from tick to tick
   typedef struct packed {
      logic [2:0]  step_index;
      logic [3:0]  step_counter;
      logic        plan_running;
      logic        step_active;
      logic        plan_done;
      logic [31:0] step_start_time;
   } plan_state_type;

   // one result word
   typedef struct packed {
      status_type         status;
      logic        [3:0]  step_number;
      logic               reference_valid;
      logic signed [31:0] reference_x;
      logic signed [15:0] reference_yaw;
   } result_type;

endpackage

FILE: rtl/maneuver_plan_sequencer_core.sv
// maneuver_plan_sequencer_core: top level of the maneuver plan sequencer
// depends on mps_pkg, mps_csr_regs and mps_step_eval
//
//   channel  direction  handshake          word
//   req_     in         valid / stall      one control tick
//   rsp_     out        valid / stall      status, step number and reference
//   csr_     in         valid / ready      register index and write data
//
// a tick is taken into the input register, evaluated combinationally and
// lands in the result register; one tick per cycle sustained while rsp_stall
// is low. the plan state register updates as a tick moves into the result
// register. synchronous active-high reset clears the valid flags and sets
// the plan state to a completed run at step 0. a stalled result stalls the
// input register only, so one further tick is taken while a result waits.
module maneuver_plan_sequencer_core import mps_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   // tick input
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_start_request,
   input  logic                           req_controller_active,
   input  logic        [31:0]             req_time_ms,
   input  logic signed [31:0]             req_pos_x,
   input  logic signed [31:0]             req_tof_left,
   input  logic signed [31:0]             req_tof_mid,
   input  logic signed [31:0]             req_tof_right,
   // result output
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic        [1:0]              rsp_status,
   output logic        [3:0]              rsp_step_number,
   output logic                           rsp_reference_valid,
   output logic signed [31:0]             rsp_reference_x,
   output logic signed [15:0]             rsp_reference_yaw,
   // configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic        [CsrIndexWidth-1:0] csr_index,
   input  logic        [CsrDataWidth-1:0]  csr_data
);

   logic                    s1_valid_ff, s1_valid_in;
   tick_type                s1_tick_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_word_ff;
   plan_state_type          state_ff;
   plan_state_type          state_nxt;
   result_type              result;
   logic [PlanLenWidth-1:0] plan_length;
   step_table_type          step_table;
   logic                    out_free;
   logic                    advance;
   logic                    accept;

   // configuration registers
   assign csr_ready = 1'b1;

   mps_csr_regs u_csr_regs (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (csr_valid && csr_ready),
      .wr_index    (csr_index_type'(csr_index)),
      .wr_data     (csr_data),
      .plan_length (plan_length),
      .step_table  (step_table)
   );

   // handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tick_ff <= '{start_request:     req_start_request,
                         controller_active: req_controller_active,
                         time_ms:           req_time_ms,
                         pos_x:             req_pos_x,
                         tof_left:          req_tof_left,
                         tof_mid:           req_tof_mid,
                         tof_right:         req_tof_right};
      end
   end

   // tick evaluation
   mps_step_eval u_step_eval (
      .tick        (s1_tick_ff),
      .state_cur   (state_ff),
      .plan_length (plan_length),
      .step_table  (step_table),
      .state_nxt   (state_nxt),
      .result      (result)
   );

   // plan state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff             <= 1'b0;
         state_ff.step_index      <= '0;
         state_ff.step_counter    <= 4'd1;
         state_ff.plan_running    <= 1'b0;
         state_ff.step_active     <= 1'b0;
         state_ff.plan_done       <= 1'b1;
         state_ff.step_start_time <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_word_ff.status;
   assign rsp_step_number     = rsp_word_ff.step_number;
   assign rsp_reference_valid = rsp_word_ff.reference_valid;
   assign rsp_reference_x     = rsp_word_ff.reference_x;
   assign rsp_reference_yaw   = rsp_word_ff.reference_yaw;

   // the counter always runs one ahead of the index
   a_counter_tracks_index: assert property (@(posedge clock) disable iff (reset)
      state_ff.step_counter == ({1'b0, state_ff.step_index} + 4'd1))
      else $error("step counter out of step with index");

   // a completed plan is never marked running
   a_done_not_running: assert property (@(posedge clock) disable iff (reset)
      state_ff.plan_done |-> !state_ff.plan_running)
      else $error("plan done while running");

   // no reference outside a running step
   a_ref_only_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_word_ff.status != ST_RUNNING) |->
         !rsp_word_ff.reference_valid && (rsp_word_ff.step_number == 4'd0))
      else $error("reference or step number outside a running step");

   // reference fields are zero when no reference is issued
   a_ref_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.reference_valid |->
         (rsp_word_ff.reference_x == '0) && (rsp_word_ff.reference_yaw == '0))
      else $error("reference fields set without a reference");

   // input side stalls only when a tick is held in the input register
   a_stall_has_tick: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled with nothing held");

endmodule

FILE: rtl/mps_csr_regs.sv
// mps_csr_regs: plan length and step table registers of the sequencer
// depends on mps_pkg for register indexes and the step word layout
module mps_csr_regs import mps_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  csr_index_type                    wr_index,
   input  logic        [CsrDataWidth-1:0]   wr_data,
   output logic        [PlanLenWidth-1:0]   plan_length,
   output step_table_type                   step_table
);

   logic [PlanLenWidth-1:0] plan_length_ff;
   step_table_type          step_table_ff;

   // register writes, index 0 is the plan length, the rest are step words
   always_ff @(posedge clock) begin
      if (reset) begin
         plan_length_ff <= '0;
         step_table_ff  <= '0;
      end else if (wr_en) begin
         unique case (wr_index)
            CSR_PLAN_LENGTH: plan_length_ff   <= wr_data[PlanLenWidth-1:0];
            CSR_STEP_WORD_0: step_table_ff[0] <= step_word_type'(wr_data);
            CSR_STEP_WORD_1: step_table_ff[1] <= step_word_type'(wr_data);
            CSR_STEP_WORD_2: step_table_ff[2] <= step_word_type'(wr_data);
            CSR_STEP_WORD_3: step_table_ff[3] <= step_word_type'(wr_data);
            CSR_STEP_WORD_4: step_table_ff[4] <= step_word_type'(wr_data);
            CSR_STEP_WORD_5: step_table_ff[5] <= step_word_type'(wr_data);
            CSR_STEP_WORD_6: step_table_ff[6] <= step_word_type'(wr_data);
            default: ;
         endcase
      end
   end

   assign plan_length = plan_length_ff;
   assign step_table  = step_table_ff;

endmodule

FILE: rtl/mps_step_eval.sv
// mps_step_eval: one tick of the plan sequencer, state in, next state and result out
// depends on mps_pkg for the tick, state, result and step word types
module mps_step_eval import mps_pkg::*; (
   input  tick_type                   tick,
   input  plan_state_type             state_cur,
   input  logic [PlanLenWidth-1:0]    plan_length,
   input  step_table_type             step_table,
   output plan_state_type             state_nxt,
   output result_type                 result
);

   step_word_type      word;
   logic        [2:0]  cur_index;
   logic signed [32:0] ref_sum;
   logic signed [31:0] ref_sat;
   logic        [31:0] elapsed;
   logic               go;

   // index in use this tick, a start request on a completed run begins at step 0
   assign cur_index = (tick.start_request && state_cur.plan_done) ? 3'd0
                                                                  : state_cur.step_index;

   // step word of the current index, the slot past the table reads as zero
   always_comb begin
      word = '0;
      if (cur_index != 3'(MaxSteps)) begin
         word = step_table[cur_index];
      end
   end

   // reference x before saturation
   always_comb begin
      unique case (word.maneuver)
         MAN_PARK:                                   ref_sum = 33'(tick.pos_x);
         MAN_REVERSE, MAN_REVERSE_LEFT, MAN_REVERSE_RIGHT:
            ref_sum = 33'(tick.pos_x) - OffsetQ16;
         MAN_DRIVE, MAN_DRIVE_LEFT, MAN_DRIVE_RIGHT:
            ref_sum = 33'(tick.pos_x) + OffsetQ16;
         default:                                    ref_sum = '0;
      endcase
      if (ref_sum > Int32Max) begin
         ref_sat = Int32Max[31:0];
      end else if (ref_sum < Int32Min) begin
         ref_sat = Int32Min[31:0];
      end else begin
         ref_sat = ref_sum[31:0];
      end
   end

   // transition test, elapsed time is unsigned and a negative duration threshold passes at once
   assign elapsed = tick.time_ms - state_cur.step_start_time;

   always_comb begin
      unique case (word.transition)
         TR_DURATION:     go = word.threshold[31] || (elapsed > $unsigned(word.threshold));
         TR_X_ABOVE:      go = tick.pos_x     > word.threshold;
         TR_X_BELOW:      go = tick.pos_x     < word.threshold;
         TR_LEFT_ABOVE:   go = tick.tof_left  > word.threshold;
         TR_LEFT_BELOW:   go = tick.tof_left  < word.threshold;
         TR_MIDDLE_ABOVE: go = tick.tof_mid   > word.threshold;
         TR_MIDDLE_BELOW: go = tick.tof_mid   < word.threshold;
         TR_RIGHT_ABOVE:  go = tick.tof_right > word.threshold;
         TR_RIGHT_BELOW:  go = tick.tof_right < word.threshold;
         default:         go = 1'b0;
      endcase
   end

   // sequencer update for this tick
   always_comb begin
      logic past_end;
      state_nxt = state_cur;
      result    = '0;
      result.status = ST_IDLE;
      past_end  = 1'b0;

      // start request only restarts a completed run
      if (tick.start_request && state_cur.plan_done) begin
         state_nxt.step_index   = '0;
         state_nxt.step_counter = 4'd1;
         state_nxt.step_active  = 1'b0;
         state_nxt.plan_running = 1'b0;
         state_nxt.plan_done    = 1'b0;
      end

      if (!state_nxt.plan_done && tick.controller_active) begin
         past_end = {1'b0, state_nxt.step_index} >= {1'b0, plan_length};
         if (state_nxt.plan_running && past_end) begin
            state_nxt.plan_running = 1'b0;
            state_nxt.plan_done    = 1'b1;
            result.status          = ST_COMPLETED;
         end else if (!state_nxt.plan_running && past_end) begin
            result.status = ST_EMPTY;
         end else begin
            state_nxt.plan_running = 1'b1;
            if (!state_nxt.step_active) begin
               // step begins: issue its reference
               result.reference_valid = 1'b1;
               result.reference_x     = ref_sat;
               unique case (word.maneuver)
                  MAN_REVERSE_LEFT, MAN_DRIVE_LEFT:   result.reference_yaw = YawQuarter;
                  MAN_REVERSE_RIGHT, MAN_DRIVE_RIGHT: result.reference_yaw = -YawQuarter;
                  default:                            result.reference_yaw = '0;
               endcase
               state_nxt.step_start_time = tick.time_ms;
               state_nxt.step_active     = 1'b1;
            end else if (go) begin
               state_nxt.step_index   = state_nxt.step_index + 3'd1;
               state_nxt.step_counter = state_nxt.step_counter + 4'd1;
               state_nxt.step_active  = 1'b0;
            end
            result.status      = ST_RUNNING;
            result.step_number = state_nxt.step_counter;
         end
      end
   end

endmodule

FILE: verif/testbench.sv
// testbench: self-checking bench for maneuver_plan_sequencer_core
// keeps its own copy of the plan state and step table, predicts every result word
// depends on mps_pkg and maneuver_plan_sequencer_core
module testbench;
   import mps_pkg::*;

   // transition code with no meaning, the step never ends
   localparam logic [3:0] TrUnknown = 4'hF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_start_request = 1'b0;
   logic                      req_controller_active = 1'b0;
   logic        [31:0]        req_time_ms = '0;
   logic signed [31:0]        req_pos_x = '0;
   logic signed [31:0]        req_tof_left = '0;
   logic signed [31:0]        req_tof_mid = '0;
   logic signed [31:0]        req_tof_right = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic        [1:0]         rsp_status;
   logic        [3:0]         rsp_step_number;
   logic                      rsp_reference_valid;
   logic signed [31:0]        rsp_reference_x;
   logic signed [15:0]        rsp_reference_yaw;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CsrIndexWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0]   csr_data = '0;

   // configuration as the block should hold it
   logic [2:0]     plan_len = '0;
   step_table_type step_table = '0;

   // plan state as the block should hold it
   logic [2:0]  seq_index = '0;
   logic [3:0]  seq_counter = 4'd1;
   logic        seq_running = 1'b0;
   logic        seq_active = 1'b0;
   logic        seq_done = 1'b1;
   logic [31:0] seq_start_ms = '0;

   tick_type    pending_ticks [$];
   result_type  due_results [$];
   tick_type    bus_tick;
   logic        tick_on_bus = 1'b0;
   logic        steady_phase = 1'b0;
   logic [31:0] clock_ms = 32'hFFFF_FFF0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned mismatch_count = 0;
   result_type  seen_result;
   result_type  want_result;

   maneuver_plan_sequencer_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_start_request     (req_start_request),
      .req_controller_active (req_controller_active),
      .req_time_ms           (req_time_ms),
      .req_pos_x             (req_pos_x),
      .req_tof_left          (req_tof_left),
      .req_tof_mid           (req_tof_mid),
      .req_tof_right         (req_tof_right),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_step_number       (rsp_step_number),
      .rsp_reference_valid   (rsp_reference_valid),
      .rsp_reference_x       (rsp_reference_x),
      .rsp_reference_yaw     (rsp_reference_yaw),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always #6 clock = ~clock;

   // gap length: mostly none or short, now and then long
   function automatic int unsigned pick_pause();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (steady_phase || roll < 5) return 0;
      if (roll < 9) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // advance the plan by one tick and return the result word it yields
   function automatic result_type sequence_tick(tick_type t);
      result_type         r;
      step_word_type      w;
      logic signed [33:0] x_ref;
      logic signed [31:0] thr;
      logic [31:0]        elapsed;
      logic               go;
      logic               past_end;
      r = '0;
      r.status = ST_IDLE;
      go = 1'b0;
      // restart only once the previous run has completed
      if (t.start_request && seq_done) begin
         seq_index = '0;
         seq_counter = 4'd1;
         seq_active = 1'b0;
         seq_running = 1'b0;
         seq_done = 1'b0;
      end
      if (!seq_done && t.controller_active) begin
         past_end = seq_index >= plan_len;
         if (seq_running && past_end) begin
            seq_running = 1'b0;
            seq_done = 1'b1;
            r.status = ST_COMPLETED;
         end else if (!seq_running && past_end) begin
            r.status = ST_EMPTY;
         end else begin
            w = step_table[seq_index];
            thr = w.threshold;
            seq_running = 1'b1;
            if (!seq_active) begin
               // step entry: issue the reference
               r.reference_valid = 1'b1;
               x_ref = 34'(t.pos_x);
               case (w.maneuver)
                  MAN_PARK: ;
                  MAN_REVERSE, MAN_REVERSE_LEFT, MAN_REVERSE_RIGHT: x_ref = x_ref - OffsetQ16;
                  MAN_DRIVE, MAN_DRIVE_LEFT, MAN_DRIVE_RIGHT: x_ref = x_ref + OffsetQ16;
                  default: x_ref = '0;
               endcase
               case (w.maneuver)
                  MAN_REVERSE_LEFT, MAN_DRIVE_LEFT: r.reference_yaw = YawQuarter;
                  MAN_REVERSE_RIGHT, MAN_DRIVE_RIGHT: r.reference_yaw = -YawQuarter;
                  default: r.reference_yaw = '0;
               endcase
               if (x_ref > Int32Max) r.reference_x = Int32Max[31:0];
               else if (x_ref < Int32Min) r.reference_x = Int32Min[31:0];
               else r.reference_x = x_ref[31:0];
               seq_start_ms = t.time_ms;
               seq_active = 1'b1;
            end else begin
               // strict threshold tests, a negative duration passes at once
               elapsed = t.time_ms - seq_start_ms;
               case (w.transition)
                  TR_DURATION:     go = thr[31] || (elapsed > $unsigned(thr));
                  TR_X_ABOVE:      go = t.pos_x > thr;
                  TR_X_BELOW:      go = t.pos_x < thr;
                  TR_LEFT_ABOVE:   go = t.tof_left > thr;
                  TR_LEFT_BELOW:   go = t.tof_left < thr;
                  TR_MIDDLE_ABOVE: go = t.tof_mid > thr;
                  TR_MIDDLE_BELOW: go = t.tof_mid < thr;
                  TR_RIGHT_ABOVE:  go = t.tof_right > thr;
                  TR_RIGHT_BELOW:  go = t.tof_right < thr;
                  default:         go = 1'b0;
               endcase
               if (go) begin
                  seq_index = seq_index + 3'd1;
                  seq_counter = seq_counter + 4'd1;
                  seq_active = 1'b0;
               end
            end
            r.status = ST_RUNNING;
            r.step_number = seq_counter;
         end
      end
      return r;
   endfunction

   // sensor reading: mostly near the thresholds, sometimes anywhere or at the ends
   function automatic logic signed [31:0] random_reading();
      case ($urandom_range(0, 15))
         0: return $urandom;
         1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2: return 32'h8000_0000 + $urandom_range(0, 3);
         default: return $urandom_range(0, 160) - 80;
      endcase
   endfunction

   function automatic logic [38:0] random_step_word();
      step_word_type w;
      w.maneuver = maneuver_type'($urandom_range(0, 7));
      if ($urandom_range(0, 15) == 0) w.transition = step_exit_type'($urandom_range(9, 15));
      else w.transition = step_exit_type'($urandom_range(0, 8));
      if ($urandom_range(0, 7) == 0) w.threshold = $urandom;
      else if (w.transition == TR_DURATION) w.threshold = $urandom_range(0, 12);
      else w.threshold = $urandom_range(0, 120) - 60;
      return w;
   endfunction

   // one register write; valid stays up for the next write of a batch
   task automatic write_reg(input csr_index_type idx, input logic [38:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PLAN_LENGTH) plan_len = data[2:0];
      else step_table[int'(idx) - 1] = step_word_type'(data);
   endtask

   task automatic program_plan(input logic [2:0] len, input logic [38:0] words [7]);
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      write_reg(CSR_PLAN_LENGTH, {noise[38:3], len});
      for (int i = 0; i < MaxSteps; i++) write_reg(csr_index_type'(i + 1), words[i]);
      csr_valid <= 1'b0;
   endtask

   task automatic push_plain(input logic start, input logic active);
      tick_type t;
      t = '0;
      t.start_request = start;
      t.controller_active = active;
      t.time_ms = clock_ms;
      clock_ms += 1;
      pending_ticks.push_back(t);
   endtask

   // per step: an entry word at extreme positions, then a word that meets the test
   task automatic walk_plan(input int steps);
      tick_type           t;
      step_word_type      w;
      logic signed [31:0] level;
      for (int i = 0; i < steps; i++) begin
         w = step_table[i];
         t = '0;
         t.start_request = (i == 0);
         t.controller_active = 1'b1;
         t.time_ms = clock_ms;
         t.pos_x = i[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         t.tof_left = 32'sh8000_0000;
         t.tof_mid = 32'sh7FFF_FFFF;
         t.tof_right = '1;
         pending_ticks.push_back(t);
         // odd transition codes test above, even ones below
         level = w.transition[0] ? w.threshold + 1 : w.threshold - 1;
         t.start_request = 1'b0;
         t.time_ms = clock_ms + 6;
         t.pos_x = level;
         t.tof_left = level;
         t.tof_mid = level;
         t.tof_right = level;
         pending_ticks.push_back(t);
         clock_ms += 7;
      end
   endtask

   task automatic wait_drained();
      while (pending_ticks.size() != 0 || tick_on_bus || due_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // tick driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            due_results.push_back(sequence_tick(bus_tick));
            tick_on_bus = 1'b0;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               bus_tick = pending_ticks.pop_front();
               tick_on_bus = 1'b1;
               req_start_request <= bus_tick.start_request;
               req_controller_active <= bus_tick.controller_active;
               req_time_ms <= bus_tick.time_ms;
               req_pos_x <= bus_tick.pos_x;
               req_tof_left <= bus_tick.tof_left;
               req_tof_mid <= bus_tick.tof_mid;
               req_tof_right <= bus_tick.tof_right;
               req_valid <= 1'b1;
               gap_left = pick_pause();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_result.status = status_type'(rsp_status);
            seen_result.step_number = rsp_step_number;
            seen_result.reference_valid = rsp_reference_valid;
            seen_result.reference_x = rsp_reference_x;
            seen_result.reference_yaw = rsp_reference_yaw;
            if (due_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result word: status %0d step %0d", rsp_status,
                           rsp_step_number);
            end else begin
               want_result = due_results.pop_front();
               if (seen_result !== want_result) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch (expected/actual): status %0d/%0d step %0d/%0d ",
                               "valid %0b/%0b x %0d/%0d yaw %0d/%0d"},
                              want_result.status, seen_result.status,
                              want_result.step_number, seen_result.step_number,
                              want_result.reference_valid, seen_result.reference_valid,
                              want_result.reference_x, seen_result.reference_x,
                              want_result.reference_yaw, seen_result.reference_yaw);
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_pause();
         end
      end
   end

   // stimulus
   initial begin
      tick_type      t;
      step_word_type w;
      logic [38:0]   words [7];
      logic [2:0]    len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // maneuver and transition codes 0 to 6 in turn, time wrapping
      for (int i = 0; i < MaxSteps; i++) begin
         w.maneuver = maneuver_type'(i);
         w.transition = step_exit_type'(i);
         w.threshold = (i == 0) ? 32'sd5 : 32'sd1000;
         words[i] = w;
      end
      // empty plan, then a paused tick
      program_plan(3'd0, words);
      push_plain(1'b1, 1'b1);
      push_plain(1'b0, 1'b0);
      wait_drained();
      program_plan(3'd7, words);
      walk_plan(7);
      push_plain(1'b0, 1'b1);
      push_plain(1'b0, 1'b1);
      wait_drained();

      // unknown maneuver, negative duration, right range tests, a step that never ends
      words[0] = {-32'sd5, TR_DURATION, MAN_UNKNOWN};
      words[1] = {32'sd1000, TR_RIGHT_ABOVE, MAN_DRIVE_LEFT};
      words[2] = {32'sd1000, TR_RIGHT_BELOW, MAN_DRIVE_RIGHT};
      words[3] = {32'sd0, TrUnknown, MAN_PARK};
      for (int i = 4; i < MaxSteps; i++) words[i] = random_step_word();
      program_plan(3'd4, words);
      walk_plan(4);
      push_plain(1'b0, 1'b0);
      push_plain(1'b1, 1'b1);
      wait_drained();

      // random phases; the plan state runs on across table changes
      for (int phase = 0; phase < 12; phase++) begin
         steady_phase = (phase % 4 == 3);
         for (int i = 0; i < MaxSteps; i++) words[i] = random_step_word();
         len = 3'($urandom_range(1, 7));
         case (phase)
            0: len = 3'd7;
            1: len = 3'd0;
            2: begin
               len = 3'd7;
               for (int i = 0; i < MaxSteps; i++) words[i] = '1;
            end
            3: begin
               len = 3'd7;
               for (int i = 0; i < MaxSteps; i++) words[i] = '0;
            end
            default: if ($urandom_range(0, 5) == 0) len = 3'($urandom_range(0, 7));
         endcase
         program_plan(len, words);
         for (int n = 0; n < 75; n++) begin
            t.start_request = ($urandom_range(0, 7) == 0);
            t.controller_active = ($urandom_range(0, 9) != 0);
            clock_ms += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 4);
            t.time_ms = clock_ms;
            t.pos_x = random_reading();
            t.tof_left = random_reading();
            t.tof_mid = random_reading();
            t.tof_right = random_reading();
            pending_ticks.push_back(t);
         end
         wait_drained();
      end

      if (mismatch_count == 0 && due_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // run limit
   initial begin
      #6000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
